// ===== rtl/core/smc_pkg.sv =====
// Shared constants, types and divider step functions for the SMA crossover signal block.
package smc_pkg;

    localparam int FAST_LEN = 5;
    localparam int SLOW_LEN = 20;
    localparam int ATR_LEN  = 14;

    localparam int PRICE_W     = 32;
    localparam int CLOSE_DEPTH = (FAST_LEN > SLOW_LEN) ? FAST_LEN : SLOW_LEN;
    localparam int NEED_MAX    = (CLOSE_DEPTH > ATR_LEN + 1) ? CLOSE_DEPTH : (ATR_LEN + 1);
    localparam int BARS_CAP    = (NEED_MAX > 31) ? NEED_MAX : 31;
    localparam int BARS_W      = $clog2(BARS_CAP + 1);

    localparam int FAST_SUM_W  = PRICE_W + $clog2(FAST_LEN);
    localparam int SLOW_SUM_W  = PRICE_W + $clog2(SLOW_LEN);
    localparam int RANGE_SUM_W = PRICE_W + $clog2(ATR_LEN);
    localparam int SUM_MAX_W0  = (FAST_SUM_W > SLOW_SUM_W) ? FAST_SUM_W : SLOW_SUM_W;
    localparam int SUM_MAX_W   = (SUM_MAX_W0 > RANGE_SUM_W) ? SUM_MAX_W0 : RANGE_SUM_W;
    localparam int DIV_BYTES   = (SUM_MAX_W + 7) / 8;
    localparam int DIV_W       = DIV_BYTES * 8;

    localparam int MAX_LEN0 = (FAST_LEN > SLOW_LEN) ? FAST_LEN : SLOW_LEN;
    localparam int MAX_LEN  = (MAX_LEN0 > ATR_LEN) ? MAX_LEN0 : ATR_LEN;
    localparam int REM_W    = $clog2(MAX_LEN) + 1;

    localparam logic [REM_W-1:0] FAST_DIV  = REM_W'(FAST_LEN);
    localparam logic [REM_W-1:0] SLOW_DIV  = REM_W'(SLOW_LEN);
    localparam logic [REM_W-1:0] RANGE_DIV = REM_W'(ATR_LEN);

    localparam int MULT_W   = 8;
    localparam int PROD_W   = PRICE_W + MULT_W;
    localparam int FRAC_W   = 4;
    localparam int OFF_W    = PROD_W - FRAC_W;
    localparam int LEVEL_W  = 34;
    localparam int LV_W     = OFF_W + 2;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_MULT   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_MULT = CFG_IDX_W'(1);
    localparam logic [MULT_W-1:0]    STOP_MULT_RST   = MULT_W'(24);
    localparam logic [MULT_W-1:0]    TARGET_MULT_RST = MULT_W'(32);

    typedef enum logic [1:0] {
        SIG_HOLD = 2'd0,
        SIG_BUY  = 2'd1,
        SIG_SELL = 2'd2
    } t_signal;

    typedef struct packed {
        logic [MULT_W-1:0] stop_mult;
        logic [MULT_W-1:0] target_mult;
    } t_cfg;

    // One classified bar: its close, the updated window sums and which windows are full.
    typedef struct packed {
        logic [PRICE_W-1:0]     close;
        logic [FAST_SUM_W-1:0]  fast_sum;
        logic [SLOW_SUM_W-1:0]  slow_sum;
        logic [RANGE_SUM_W-1:0] range_sum;
        logic                   fast_ok;
        logic                   slow_ok;
        logic                   atr_ok;
    } t_bar_rec;

    typedef struct packed {
        t_signal              signal;
        logic [PRICE_W-1:0]   entry;
        logic [LEVEL_W-1:0]   stop;
        logic [LEVEL_W-1:0]   target;
        logic [PRICE_W-1:0]   fast_avg;
        logic [PRICE_W-1:0]   slow_avg;
        logic [PRICE_W-1:0]   atr;
    } t_result;

    typedef struct packed {
        logic [DIV_W-1:0] num;
        logic [DIV_W-1:0] quo;
        logic [REM_W-1:0] rem;
    } t_div_lane;

    typedef struct packed {
        logic [7:0]       q;
        logic [REM_W-1:0] rem;
    } t_div_step;

    // Eight restoring steps of a division by a small constant divisor.
    function automatic t_div_step div_byte(input logic [REM_W-1:0] rem_in,
                                           input logic [7:0]       bits,
                                           input logic [REM_W-1:0] divisor);
        logic [REM_W:0]   acc;
        logic [REM_W-1:0] r;
        t_div_step        res;
        r   = rem_in;
        res = '0;
        for (int i = 7; i >= 0; i--) begin
            acc = {r, bits[i]};
            if (acc >= {1'b0, divisor}) begin
                acc      = acc - {1'b0, divisor};
                res.q[i] = 1'b1;
            end else begin
                res.q[i] = 1'b0;
            end
            r = acc[REM_W-1:0];
        end
        res.rem = r;
        return res;
    endfunction

    // Consume the top byte of the remaining dividend and append a quotient byte.
    function automatic t_div_lane div_lane_step(input t_div_lane lane,
                                                input logic [REM_W-1:0] divisor);
        t_div_step s;
        t_div_lane o;
        s     = div_byte(lane.rem, lane.num[DIV_W-1 -: 8], divisor);
        o.num = lane.num << 8;
        o.quo = {lane.quo[DIV_W-9:0], s.q};
        o.rem = s.rem;
        return o;
    endfunction

endpackage

// ===== rtl/core/sma_crossover_atr_signal.sv =====
// Top level of the moving-average crossover signal block with ATR stop and target levels.
//
// Use: price bars enter on the slave stream, one bar per word; tdata carries high, low
// and close in units of 1/10000. Each bar yields exactly one result word on the master
// stream: the trade signal in tuser and the entry, stop, target and the three averages
// in tdata. The configuration channel sets the stop and target multipliers (Q4); it is
// always ready and should only be written while no bar is in flight.
// Pipeline: the true range is registered together with the bar, then the window sums go
// into the queue, through the byte-wise constant divider stages, to the registered signal
// decision and multiplier, and last to the level adders and output register.
// Throughput: one bar per cycle while the receiver keeps tready high, set by the window
// sum update in the front end; the dividers and the level path are fully pipelined.
// Stalls: when the receiver holds tready low the output word stays put and the back end
// freezes; the four-entry queue keeps the front end taking bars until it fills, and only
// then does s_axis_tready fall.
// Reset: synchronous, active low; windows, sums, bar count and previous close clear to
// zero, the multipliers return to 1.5 and 2.0, and both streams go empty.
module sma_crossover_atr_signal (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Bar input.
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata from bit 0: high_price[31:0], low_price[63:32], close_price[95:64]
    input  logic [95:0]                     s_axis_tdata,
    // Result output.
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tdata from bit 0: entry_price[31:0], stop_level[65:32], target_level[99:66],
    // fast_average[131:100], slow_average[163:132], average_range[195:164], zero pad
    output logic [199:0]                    m_axis_tdata,
    // tuser from bit 0: trade_signal[1:0]
    output logic [1:0]                      m_axis_tuser,
    // Configuration writes.
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [smc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [smc_pkg::MULT_W-1:0]      i_cfg_data
);

    logic [smc_pkg::MULT_W-1:0] r_stop_mult;
    logic [smc_pkg::MULT_W-1:0] r_target_mult;
    smc_pkg::t_cfg              cfg;

    logic                       push;
    logic                       full;
    logic                       pop;
    logic                       rec_valid;
    smc_pkg::t_bar_rec          rec_in;
    smc_pkg::t_bar_rec          rec_out;
    smc_pkg::t_result           result;

    assign o_cfg_ready     = 1'b1;
    assign cfg.stop_mult   = r_stop_mult;
    assign cfg.target_mult = r_target_mult;

    // Writes to indexes beyond the register list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop_mult   <= smc_pkg::STOP_MULT_RST;
            r_target_mult <= smc_pkg::TARGET_MULT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                smc_pkg::CFG_STOP_MULT:   r_stop_mult   <= i_cfg_data;
                smc_pkg::CFG_TARGET_MULT: r_target_mult <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    smc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_high  (s_axis_tdata[31:0]),
        .i_low   (s_axis_tdata[63:32]),
        .i_close (s_axis_tdata[95:64]),
        .o_push  (push),
        .o_rec   (rec_in),
        .i_full  (full)
    );

    smc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (rec_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (rec_valid),
        .o_data  (rec_out)
    );

    smc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec_valid (rec_valid),
        .i_rec       (rec_out),
        .o_rec_pop   (pop),
        .i_cfg       (cfg),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_result    (result)
    );

    // Pack the result word, first field in the lowest bits.
    assign m_axis_tuser = result.signal;
    assign m_axis_tdata = {4'b0000, result.atr, result.slow_avg, result.fast_avg,
                           result.target, result.stop, result.entry};

endmodule

// ===== rtl/core/smc_front.sv =====
// Front end: accepts bars, forms the true range and keeps the window sums.
module smc_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [smc_pkg::PRICE_W-1:0]   i_high,
    input  logic [smc_pkg::PRICE_W-1:0]   i_low,
    input  logic [smc_pkg::PRICE_W-1:0]   i_close,
    output logic                          o_push,
    output smc_pkg::t_bar_rec             o_rec,
    input  logic                          i_full
);

    logic                              r_f_valid;
    logic [smc_pkg::PRICE_W-1:0]       r_f_close;
    logic [smc_pkg::PRICE_W-1:0]       r_f_tr;
    logic [smc_pkg::PRICE_W-1:0]       r_prev_close;
    logic [smc_pkg::PRICE_W-1:0]       r_close_win [smc_pkg::CLOSE_DEPTH];
    logic [smc_pkg::PRICE_W-1:0]       r_range_win [smc_pkg::ATR_LEN];
    logic [smc_pkg::FAST_SUM_W-1:0]    r_fast_sum;
    logic [smc_pkg::SLOW_SUM_W-1:0]    r_slow_sum;
    logic [smc_pkg::RANGE_SUM_W-1:0]   r_range_sum;
    logic [smc_pkg::BARS_W-1:0]        r_bars;

    logic [smc_pkg::FAST_SUM_W-1:0]    n_fast_sum;
    logic [smc_pkg::SLOW_SUM_W-1:0]    n_slow_sum;
    logic [smc_pkg::RANGE_SUM_W-1:0]   n_range_sum;
    logic [smc_pkg::BARS_W-1:0]        n_bars;
    logic [smc_pkg::PRICE_W-1:0]       n_tr;

    logic                              accept;
    logic signed [smc_pkg::PRICE_W:0]  d_hl;
    logic signed [smc_pkg::PRICE_W:0]  tr_w;
    logic [smc_pkg::PRICE_W-1:0]       a_hp;
    logic [smc_pkg::PRICE_W-1:0]       a_lp;

    assign o_push  = r_f_valid && !i_full;
    assign o_ready = !r_f_valid || !i_full;
    assign accept  = i_valid && o_ready;

    // True range against the previous accepted close.
    always_comb begin
        d_hl = $signed({1'b0, i_high}) - $signed({1'b0, i_low});
        a_hp = (i_high >= r_prev_close) ? (i_high - r_prev_close) : (r_prev_close - i_high);
        a_lp = (i_low  >= r_prev_close) ? (i_low  - r_prev_close) : (r_prev_close - i_low);
        tr_w = d_hl;
        if ($signed({1'b0, a_hp}) > tr_w) begin
            tr_w = $signed({1'b0, a_hp});
        end
        if ($signed({1'b0, a_lp}) > tr_w) begin
            tr_w = $signed({1'b0, a_lp});
        end
        n_tr = tr_w[smc_pkg::PRICE_W-1:0];
    end

    always_comb begin
        n_fast_sum  = r_fast_sum
                    - smc_pkg::FAST_SUM_W'(r_close_win[smc_pkg::FAST_LEN-1])
                    + smc_pkg::FAST_SUM_W'(r_f_close);
        n_slow_sum  = r_slow_sum
                    - smc_pkg::SLOW_SUM_W'(r_close_win[smc_pkg::SLOW_LEN-1])
                    + smc_pkg::SLOW_SUM_W'(r_f_close);
        n_range_sum = r_range_sum
                    - smc_pkg::RANGE_SUM_W'(r_range_win[smc_pkg::ATR_LEN-1])
                    + smc_pkg::RANGE_SUM_W'(r_f_tr);
        n_bars      = (r_bars < smc_pkg::BARS_W'(smc_pkg::BARS_CAP))
                    ? r_bars + smc_pkg::BARS_W'(1) : r_bars;

        o_rec.close     = r_f_close;
        o_rec.fast_sum  = n_fast_sum;
        o_rec.slow_sum  = n_slow_sum;
        o_rec.range_sum = n_range_sum;
        o_rec.fast_ok   = n_bars >= smc_pkg::BARS_W'(smc_pkg::FAST_LEN);
        o_rec.slow_ok   = n_bars >= smc_pkg::BARS_W'(smc_pkg::SLOW_LEN);
        o_rec.atr_ok    = n_bars >= smc_pkg::BARS_W'(smc_pkg::ATR_LEN + 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid    <= 1'b0;
            r_prev_close <= '0;
            r_fast_sum   <= '0;
            r_slow_sum   <= '0;
            r_range_sum  <= '0;
            r_bars       <= '0;
            for (int i = 0; i < smc_pkg::CLOSE_DEPTH; i++) begin
                r_close_win[i] <= '0;
            end
            for (int i = 0; i < smc_pkg::ATR_LEN; i++) begin
                r_range_win[i] <= '0;
            end
        end else begin
            if (accept) begin
                r_f_valid    <= 1'b1;
                r_prev_close <= i_close;
            end else if (o_push) begin
                r_f_valid <= 1'b0;
            end
            if (o_push) begin
                r_fast_sum  <= n_fast_sum;
                r_slow_sum  <= n_slow_sum;
                r_range_sum <= n_range_sum;
                r_bars      <= n_bars;
                for (int i = smc_pkg::CLOSE_DEPTH - 1; i > 0; i--) begin
                    r_close_win[i] <= r_close_win[i-1];
                end
                r_close_win[0] <= r_f_close;
                for (int i = smc_pkg::ATR_LEN - 1; i > 0; i--) begin
                    r_range_win[i] <= r_range_win[i-1];
                end
                r_range_win[0] <= r_f_tr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_f_close <= i_close;
            r_f_tr    <= n_tr;
        end
    end

endmodule

// ===== rtl/core/smc_fifo.sv =====
// Short queue of classified bars between the front end and the back end.
module smc_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  smc_pkg::t_bar_rec  i_data,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_valid,
    output smc_pkg::t_bar_rec  o_data
);

    smc_pkg::t_bar_rec               r_mem [smc_pkg::FIFO_DEPTH];
    logic [smc_pkg::FIFO_AW-1:0]     r_wr_ptr;
    logic [smc_pkg::FIFO_AW-1:0]     r_rd_ptr;
    logic [smc_pkg::FIFO_AW:0]       r_count;

    assign o_full  = r_count == (smc_pkg::FIFO_AW + 1)'(smc_pkg::FIFO_DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + smc_pkg::FIFO_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + smc_pkg::FIFO_AW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (smc_pkg::FIFO_AW + 1)'(1);
                2'b01:   r_count <= r_count - (smc_pkg::FIFO_AW + 1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (smc_pkg::FIFO_AW + 1)'(smc_pkg::FIFO_DEPTH))
        else $error("queue fill count beyond depth");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("pop from empty queue");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !i_pop |-> !o_full)
        else $error("push into full queue");
`endif

endmodule

// ===== rtl/core/smc_back.sv =====
// Back end: divides the window sums, decides the signal and forms stop and target levels.
module smc_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_rec_valid,
    input  smc_pkg::t_bar_rec  i_rec,
    output logic               o_rec_pop,
    input  smc_pkg::t_cfg      i_cfg,
    output logic               o_valid,
    input  logic               i_ready,
    output smc_pkg::t_result   o_result
);

    typedef struct packed {
        smc_pkg::t_div_lane          fast;
        smc_pkg::t_div_lane          slow;
        smc_pkg::t_div_lane          range;
        logic [smc_pkg::PRICE_W-1:0] close;
        logic                        fast_ok;
        logic                        slow_ok;
        logic                        atr_ok;
    } t_div_stage;

    localparam int LAST = smc_pkg::DIV_BYTES - 1;

    localparam logic signed [smc_pkg::LV_W-1:0] LV_MAX =
        {{(smc_pkg::LV_W - smc_pkg::LEVEL_W + 1){1'b0}}, {(smc_pkg::LEVEL_W - 1){1'b1}}};
    localparam logic signed [smc_pkg::LV_W-1:0] LV_MIN =
        {{(smc_pkg::LV_W - smc_pkg::LEVEL_W + 1){1'b1}}, {(smc_pkg::LEVEL_W - 1){1'b0}}};

    function automatic t_div_stage stage_step(input t_div_stage s);
        t_div_stage o;
        o       = s;
        o.fast  = smc_pkg::div_lane_step(s.fast,  smc_pkg::FAST_DIV);
        o.slow  = smc_pkg::div_lane_step(s.slow,  smc_pkg::SLOW_DIV);
        o.range = smc_pkg::div_lane_step(s.range, smc_pkg::RANGE_DIV);
        return o;
    endfunction

    function automatic logic [smc_pkg::LEVEL_W-1:0] clamp_level(
            input logic signed [smc_pkg::LV_W-1:0] v);
        logic [smc_pkg::LEVEL_W-1:0] r;
        if (v > LV_MAX) begin
            r = LV_MAX[smc_pkg::LEVEL_W-1:0];
        end else if (v < LV_MIN) begin
            r = LV_MIN[smc_pkg::LEVEL_W-1:0];
        end else begin
            r = v[smc_pkg::LEVEL_W-1:0];
        end
        return r;
    endfunction

    logic                          en;
    t_div_stage                    load;
    t_div_stage                    r_div [smc_pkg::DIV_BYTES];
    t_div_stage                    n_div [smc_pkg::DIV_BYTES];
    logic [smc_pkg::DIV_BYTES-1:0] r_div_vld;

    logic                          r_m_valid;
    smc_pkg::t_signal              r_m_sig;
    logic [smc_pkg::PRICE_W-1:0]   r_m_close;
    logic [smc_pkg::PRICE_W-1:0]   r_m_fast;
    logic [smc_pkg::PRICE_W-1:0]   r_m_slow;
    logic [smc_pkg::PRICE_W-1:0]   r_m_atr;
    logic [smc_pkg::PROD_W-1:0]    r_m_sprod;
    logic [smc_pkg::PROD_W-1:0]    r_m_tprod;

    smc_pkg::t_signal              n_sig;
    logic [smc_pkg::PRICE_W-1:0]   n_fast;
    logic [smc_pkg::PRICE_W-1:0]   n_slow;
    logic [smc_pkg::PRICE_W-1:0]   n_atr;

    logic signed [smc_pkg::LV_W-1:0] ent_s;
    logic signed [smc_pkg::LV_W-1:0] soff_s;
    logic signed [smc_pkg::LV_W-1:0] toff_s;
    smc_pkg::t_result              n_res;
    smc_pkg::t_result              r_o;
    logic                          r_o_valid;

    assign en        = !r_o_valid || i_ready;
    assign o_rec_pop = en && i_rec_valid;
    assign o_valid   = r_o_valid;
    assign o_result  = r_o;

    always_comb begin
        load.fast.num  = smc_pkg::DIV_W'(i_rec.fast_sum);
        load.fast.quo  = '0;
        load.fast.rem  = '0;
        load.slow.num  = smc_pkg::DIV_W'(i_rec.slow_sum);
        load.slow.quo  = '0;
        load.slow.rem  = '0;
        load.range.num = smc_pkg::DIV_W'(i_rec.range_sum);
        load.range.quo = '0;
        load.range.rem = '0;
        load.close     = i_rec.close;
        load.fast_ok   = i_rec.fast_ok;
        load.slow_ok   = i_rec.slow_ok;
        load.atr_ok    = i_rec.atr_ok;
        n_div[0]       = stage_step(load);
        for (int k = 1; k < smc_pkg::DIV_BYTES; k++) begin
            n_div[k] = stage_step(r_div[k-1]);
        end
    end

    // Averages read zero until their window has filled; equal averages hold.
    always_comb begin
        n_fast = r_div[LAST].fast_ok  ? r_div[LAST].fast.quo[smc_pkg::PRICE_W-1:0]  : '0;
        n_slow = r_div[LAST].slow_ok  ? r_div[LAST].slow.quo[smc_pkg::PRICE_W-1:0]  : '0;
        n_atr  = r_div[LAST].atr_ok   ? r_div[LAST].range.quo[smc_pkg::PRICE_W-1:0] : '0;
        if (n_fast != '0 && n_slow != '0 && n_fast != n_slow) begin
            n_sig = (n_fast > n_slow) ? smc_pkg::SIG_BUY : smc_pkg::SIG_SELL;
        end else begin
            n_sig = smc_pkg::SIG_HOLD;
        end
    end

    always_comb begin
        ent_s  = $signed({{(smc_pkg::LV_W - smc_pkg::PRICE_W){1'b0}}, r_m_close});
        soff_s = $signed({2'b00, r_m_sprod[smc_pkg::PROD_W-1:smc_pkg::FRAC_W]});
        toff_s = $signed({2'b00, r_m_tprod[smc_pkg::PROD_W-1:smc_pkg::FRAC_W]});
        n_res.signal   = r_m_sig;
        n_res.entry    = r_m_close;
        n_res.fast_avg = r_m_fast;
        n_res.slow_avg = r_m_slow;
        n_res.atr      = r_m_atr;
        case (r_m_sig)
            smc_pkg::SIG_BUY: begin
                n_res.stop   = clamp_level(ent_s - soff_s);
                n_res.target = clamp_level(ent_s + toff_s);
            end
            smc_pkg::SIG_SELL: begin
                n_res.stop   = clamp_level(ent_s + soff_s);
                n_res.target = clamp_level(ent_s - toff_s);
            end
            default: begin
                n_res.stop   = '0;
                n_res.target = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_vld <= '0;
            r_m_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_div_vld <= {r_div_vld[smc_pkg::DIV_BYTES-2:0], i_rec_valid};
            r_m_valid <= r_div_vld[LAST];
            r_o_valid <= r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < smc_pkg::DIV_BYTES; k++) begin
                r_div[k] <= n_div[k];
            end
            r_m_sig   <= n_sig;
            r_m_close <= r_div[LAST].close;
            r_m_fast  <= n_fast;
            r_m_slow  <= n_slow;
            r_m_atr   <= n_atr;
            r_m_sprod <= smc_pkg::PROD_W'(n_atr) * smc_pkg::PROD_W'(i_cfg.stop_mult);
            r_m_tprod <= smc_pkg::PROD_W'(n_atr) * smc_pkg::PROD_W'(i_cfg.target_mult);
            r_o       <= n_res;
        end
    end

`ifndef SYNTHESIS
    a_hold_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o.signal == smc_pkg::SIG_HOLD |-> r_o.stop == '0 && r_o.target == '0)
        else $error("hold result carries nonzero levels");
    a_buy_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o.signal == smc_pkg::SIG_BUY |->
            $signed(r_o.stop) <= $signed({2'b00, r_o.entry}) &&
            $signed(r_o.target) >= $signed({2'b00, r_o.entry}))
        else $error("buy levels out of order around entry");
`endif

endmodule
